// ===== hw/rtl/qas_pkg.sv =====
// Shared types, constants and the quadrant lookup for the quarter-tile selector.
// No dependencies; every other file in hw/rtl refers to it by scoped names.
package qas_pkg;

  // Map store geometry
  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int DIM_W    = 7;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Configuration register indexes
  localparam int          CFG_IDX_W      = 4;
  localparam logic [3:0]  REG_MAP_WIDTH  = 4'd0;
  localparam logic [3:0]  REG_MAP_HEIGHT = 4'd1;

  // Raw map code that marks a wall
  localparam logic [7:0] WALL_CODE = 8'h31;

  // Quadrant numbers
  localparam logic [1:0] QUAD_TL = 2'd0;
  localparam logic [1:0] QUAD_TR = 2'd1;
  localparam logic [1:0] QUAD_BL = 2'd2;
  localparam logic [1:0] QUAD_BR = 2'd3;

  // Table column selectors
  localparam logic [2:0] SEL_NONE   = 3'd0;
  localparam logic [2:0] SEL_FULL   = 3'd1;
  localparam logic [2:0] SEL_CORNER = 3'd2;
  localparam logic [2:0] SEL_VERT   = 3'd3;
  localparam logic [2:0] SEL_HORIZ  = 3'd4;

  localparam logic [4:0] QUAD_TABLE [0:3][0:4] = '{
    '{5'd4,  5'd9,  5'd0, 5'd8,  5'd5},
    '{5'd7,  5'd10, 5'd1, 5'd11, 5'd6},
    '{5'd16, 5'd13, 5'd2, 5'd12, 5'd17},
    '{5'd19, 5'd14, 5'd3, 5'd15, 5'd18}
  };

  // Effective map size as seen by the datapath
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } dims_t;

  // One queued work item
  typedef struct packed {
    logic             kind;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             cls;
  } entry_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Pick a sub-tile index from diagonal, vertical and horizontal sameness
  function automatic logic [4:0] pick_index(input logic [1:0] quad, input logic d,
                                            input logic v, input logic h);
    logic [2:0] sel;
    if (v) begin
      sel = h ? (d ? SEL_FULL : SEL_CORNER) : SEL_VERT;
    end else begin
      sel = h ? SEL_HORIZ : SEL_NONE;
    end
    return QUAD_TABLE[quad][sel];
  endfunction

endpackage

// ===== hw/rtl/qas_front.sv =====
// Front end: configuration registers, item intake and classification.
// Depends on qas_pkg; feeds qas_queue.
module qas_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [qas_pkg::COL_W-1:0]     col,
  input  logic [qas_pkg::ROW_W-1:0]     row,
  input  logic [7:0]                    cell_code,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [qas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [qas_pkg::DIM_W-1:0]     cfg_data,
  input  qas_pkg::q_status_t            q_status,
  output logic                          push,
  output qas_pkg::entry_t               push_entry,
  output qas_pkg::dims_t                dims
);

  logic [qas_pkg::DIM_W-1:0] map_width;
  logic [qas_pkg::DIM_W-1:0] map_height;
  logic                      in_range;

  // Write configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= qas_pkg::DIM_W'(qas_pkg::MAX_COLS);
      map_height <= qas_pkg::DIM_W'(qas_pkg::MAX_ROWS);
    end else if (cfg_valid) begin
      case (cfg_index)
        qas_pkg::REG_MAP_WIDTH:  map_width  <= cfg_data;
        qas_pkg::REG_MAP_HEIGHT: map_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the registers to the store size, zero acting as one
  always_comb begin
    if (map_width == '0) begin
      dims.width = qas_pkg::DIM_W'(1);
    end else if (map_width > qas_pkg::DIM_W'(qas_pkg::MAX_COLS)) begin
      dims.width = qas_pkg::DIM_W'(qas_pkg::MAX_COLS);
    end else begin
      dims.width = map_width;
    end
    if (map_height == '0) begin
      dims.height = qas_pkg::DIM_W'(1);
    end else if (map_height > qas_pkg::DIM_W'(qas_pkg::MAX_ROWS)) begin
      dims.height = qas_pkg::DIM_W'(qas_pkg::MAX_ROWS);
    end else begin
      dims.height = map_height;
    end
  end

  // Classify: drop queries that fall outside the map
  assign in_stall = q_status.full;
  assign in_range = (qas_pkg::DIM_W'(col) < dims.width) &&
                    (qas_pkg::DIM_W'(row) < dims.height);
  assign push     = in_valid && !in_stall && ((kind == qas_pkg::KIND_WRITE) || in_range);

  assign push_entry.kind = kind;
  assign push_entry.col  = col;
  assign push_entry.row  = row;
  assign push_entry.cls  = (cell_code == qas_pkg::WALL_CODE);

endmodule

// ===== hw/rtl/qas_queue.sv =====
// Short FIFO of classified items between the front end and the back end.
// Depends on qas_pkg for the entry type and depth.
module qas_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  qas_pkg::entry_t    push_entry,
  input  logic               pop,
  output qas_pkg::entry_t    head,
  output qas_pkg::q_status_t q_status
);

  localparam int PTR_W = (qas_pkg::QUEUE_DEPTH > 1) ? $clog2(qas_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(qas_pkg::QUEUE_DEPTH + 1);

  qas_pkg::entry_t  slots [qas_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_status.full  = (count == CNT_W'(qas_pkg::QUEUE_DEPTH));
  assign q_status.empty = (count == '0);
  assign head           = slots[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(qas_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(qas_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/qas_back.sv =====
// Back end: class map row memory, three-row neighbourhood read and sub-tile pick.
// Depends on qas_pkg; drains qas_queue and drives the result register.
module qas_back (
  input  logic                      clk,
  input  logic                      rst,
  input  qas_pkg::entry_t           head,
  input  qas_pkg::q_status_t        q_status,
  output logic                      pop,
  input  qas_pkg::dims_t            dims,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [qas_pkg::COL_W-1:0] out_col,
  output logic [qas_pkg::ROW_W-1:0] out_row,
  output logic                      cell_class,
  output logic [4:0]                top_left_index,
  output logic [4:0]                top_right_index,
  output logic [4:0]                bottom_left_index,
  output logic [4:0]                bottom_right_index
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD1  = 2'd1;
  localparam logic [1:0] ST_RD2  = 2'd2;
  localparam logic [1:0] ST_CAP  = 2'd3;

  logic [qas_pkg::MAX_COLS-1:0] mem [qas_pkg::MAX_ROWS];
  logic [qas_pkg::MAX_COLS-1:0] rd_data;
  logic [qas_pkg::ROW_W-1:0]    rd_addr;
  logic                         rd_en;
  logic                         wr_en;

  logic [1:0]                state;
  logic [1:0]                state_next;
  logic [qas_pkg::COL_W-1:0] qcol;
  logic [qas_pkg::ROW_W-1:0] qrow;
  logic [2:0]                top_bits;
  logic [2:0]                mid_bits;
  logic [2:0]                bot_bits;
  logic [2:0]                cur_bits;
  logic                      load_out;

  logic top_in, bot_in, left_in, right_in, cls;
  logic up, dn, lf, rt, d_tl, d_tr, d_bl, d_br;

  // Pull the left, centre and right bits of the queried column from a row word
  always_comb begin
    cur_bits[0] = rd_data[qcol - qas_pkg::COL_W'(1)];
    cur_bits[1] = rd_data[qcol];
    cur_bits[2] = rd_data[qcol + qas_pkg::COL_W'(1)];
  end
  assign bot_bits = cur_bits;

  // Sequence: pop and read row above, read centre row, read row below, capture
  assign pop   = (state == ST_IDLE) && !q_status.empty;
  assign wr_en = pop && (head.kind == qas_pkg::KIND_WRITE);
  assign load_out = (state == ST_CAP) && (!out_valid || !out_stall);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = qrow;
    case (state)
      ST_IDLE: begin
        rd_en   = pop && (head.kind == qas_pkg::KIND_QUERY);
        rd_addr = head.row - qas_pkg::ROW_W'(1);
      end
      ST_RD1: begin
        rd_en   = 1'b1;
        rd_addr = qrow;
      end
      ST_RD2: begin
        rd_en   = 1'b1;
        rd_addr = qrow + qas_pkg::ROW_W'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (rd_en) state_next = ST_RD1;
      ST_RD1:  state_next = ST_RD2;
      ST_RD2:  state_next = ST_CAP;
      ST_CAP:  if (load_out) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Row memory: bit write, registered row read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[head.row][head.col] <= head.cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Hold the query position and the upper two rows of neighbour bits
  always_ff @(posedge clk) begin
    if (pop) begin
      qcol <= head.col;
      qrow <= head.row;
    end
    if (state == ST_RD1) begin
      top_bits <= cur_bits;
    end
    if (state == ST_RD2) begin
      mid_bits <= cur_bits;
    end
  end

  // Sameness, with neighbours outside the map counted as different
  assign top_in   = (qrow != '0);
  assign bot_in   = (qas_pkg::DIM_W'(qrow) + qas_pkg::DIM_W'(1)) < dims.height;
  assign left_in  = (qcol != '0);
  assign right_in = (qas_pkg::DIM_W'(qcol) + qas_pkg::DIM_W'(1)) < dims.width;
  assign cls      = mid_bits[1];

  assign up   = top_in && (top_bits[1] == cls);
  assign dn   = bot_in && (bot_bits[1] == cls);
  assign lf   = left_in && (mid_bits[0] == cls);
  assign rt   = right_in && (mid_bits[2] == cls);
  assign d_tl = top_in && left_in && (top_bits[0] == cls);
  assign d_tr = top_in && right_in && (top_bits[2] == cls);
  assign d_bl = bot_in && left_in && (bot_bits[0] == cls);
  assign d_br = bot_in && right_in && (bot_bits[2] == cls);

  // Result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_col            <= qcol;
      out_row            <= qrow;
      cell_class         <= cls;
      top_left_index     <= qas_pkg::pick_index(qas_pkg::QUAD_TL, d_tl, up, lf);
      top_right_index    <= qas_pkg::pick_index(qas_pkg::QUAD_TR, d_tr, up, rt);
      bottom_left_index  <= qas_pkg::pick_index(qas_pkg::QUAD_BL, d_bl, dn, lf);
      bottom_right_index <= qas_pkg::pick_index(qas_pkg::QUAD_BR, d_br, dn, rt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/quadrant_autotile_selector_core.sv =====
// Quarter-tile autotile selector: keeps a 64x64 map of wall/floor classes and
// answers sub-tile queries. The back end stores a write word as it pops it; a
// query word takes three reads of the single-port row memory (row above, own
// row, row below) and a capture into the result register, which waits while
// the output is stalled; no word is popped until a query is through. A
// two-entry queue sits behind the input and stalls it only when full; queries
// outside the configured map are taken and dropped. Map width and height are
// to be written by the user while the block is idle, which the block does not
// enforce; every cell is to be written before it, or a neighbour inside the
// map, is queried.
module quadrant_autotile_selector_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [qas_pkg::COL_W-1:0]     col,
  input  logic [qas_pkg::ROW_W-1:0]     row,
  input  logic [7:0]                    cell_code,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [qas_pkg::COL_W-1:0]     out_col,
  output logic [qas_pkg::ROW_W-1:0]     out_row,
  output logic                          cell_class,
  output logic [4:0]                    top_left_index,
  output logic [4:0]                    top_right_index,
  output logic [4:0]                    bottom_left_index,
  output logic [4:0]                    bottom_right_index,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [qas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [qas_pkg::DIM_W-1:0]     cfg_data
);

  qas_pkg::q_status_t q_status;
  qas_pkg::entry_t    push_entry;
  qas_pkg::entry_t    head;
  qas_pkg::dims_t     dims;
  logic               push;
  logic               pop;

  // Intake and classification
  qas_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .col        (col),
    .row        (row),
    .cell_code  (cell_code),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry),
    .dims       (dims)
  );

  // Decoupling queue
  qas_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_status   (q_status)
  );

  // Map store and neighbourhood evaluation
  qas_back u_back (
    .clk                (clk),
    .rst                (rst),
    .head               (head),
    .q_status           (q_status),
    .pop                (pop),
    .dims               (dims),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_col            (out_col),
    .out_row            (out_row),
    .cell_class         (cell_class),
    .top_left_index     (top_left_index),
    .top_right_index    (top_right_index),
    .bottom_left_index  (bottom_left_index),
    .bottom_right_index (bottom_right_index)
  );

  // A result always lies inside the configured map
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (qas_pkg::DIM_W'(out_row) < dims.height) &&
                  (qas_pkg::DIM_W'(out_col) < dims.width))
    else $error("result outside configured map");

  // Top row has no upper neighbour, so the top-left pick is a no-vertical entry
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_row == '0) |-> (top_left_index == 5'd4) || (top_left_index == 5'd5))
    else $error("top row result used an upper neighbour");

  // Left column has no left neighbour, so the bottom-left pick lacks horizontal
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_col == '0) |->
      (bottom_left_index == 5'd16) || (bottom_left_index == 5'd12))
    else $error("left column result used a left neighbour");

endmodule

// ===== tb/quadrant_autotile_selector_core_tb.sv =====
// Self-checking testbench for quadrant_autotile_selector_core: directed map shapes, a
// long output hold-off, and random write/query traffic checked against an in-file predictor.
// Depends on qas_pkg and the core RTL only.
`timescale 1ns / 1ps

module quadrant_autotile_selector_core_tb;

  localparam int                          CYCLE_LIMIT   = 200000;
  localparam int                          DRAIN_CYCLES  = 24;
  localparam int                          RANDOM_WORDS  = 490;
  localparam logic [qas_pkg::CFG_IDX_W-1:0] REG_SPARE_IDX = 4'd9;

  // Table columns picked by vertical, horizontal and diagonal sameness
  typedef enum int {
    SUB_ISLAND, SUB_SOLID, SUB_NOTCH, SUB_SIDE_V, SUB_SIDE_H
  } subtile_col_e;

  typedef enum int {
    STALL_NONE, STALL_LIGHT, STALL_EVERY_THIRD, STALL_HEAVY
  } stall_mode_e;

  typedef struct {
    logic [qas_pkg::COL_W-1:0] col;
    logic [qas_pkg::ROW_W-1:0] row;
    logic                      cls;
    logic [4:0]                tl;
    logic [4:0]                tr;
    logic [4:0]                bl;
    logic [4:0]                br;
  } tile_answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  logic                          kind      = qas_pkg::KIND_WRITE;
  logic [qas_pkg::COL_W-1:0]     col       = '0;
  logic [qas_pkg::ROW_W-1:0]     row       = '0;
  logic [7:0]                    cell_code = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [qas_pkg::COL_W-1:0]     out_col;
  logic [qas_pkg::ROW_W-1:0]     out_row;
  logic                          cell_class;
  logic [4:0]                    top_left_index;
  logic [4:0]                    top_right_index;
  logic [4:0]                    bottom_left_index;
  logic [4:0]                    bottom_right_index;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [qas_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [qas_pkg::DIM_W-1:0]     cfg_data  = '0;

  // Predictor state
  logic [4:0]                subtile_lut [0:3][0:4] = '{
    '{5'd4,  5'd9,  5'd0, 5'd8,  5'd5},
    '{5'd7,  5'd10, 5'd1, 5'd11, 5'd6},
    '{5'd16, 5'd13, 5'd2, 5'd12, 5'd17},
    '{5'd19, 5'd14, 5'd3, 5'd15, 5'd18}
  };
  bit                        class_map [0:qas_pkg::MAX_ROWS-1][0:qas_pkg::MAX_COLS-1];
  bit                        cell_seen [0:qas_pkg::MAX_ROWS-1][0:qas_pkg::MAX_COLS-1];
  logic [qas_pkg::DIM_W-1:0] width_reg  = 7'd64;
  logic [qas_pkg::DIM_W-1:0] height_reg = 7'd64;
  tile_answer_t              pending_tiles [$];

  // Run bookkeeping
  int          mismatch_count = 0;
  int          tiles_checked  = 0;
  int          words_sent     = 0;
  int          shapes_tried   = 0;
  int          cycle_count    = 0;
  bit          gaps_on        = 1'b1;
  int          burst_left     = 0;
  int          region_c       = 0;
  int          region_r       = 0;
  int          hold_off_req   = 0;
  int          hold_left      = 0;
  int          stretch_left   = 0;
  int          stall_phase    = 0;
  stall_mode_e stall_mode     = STALL_NONE;
  logic        stall_next;

  always #2 clk = ~clk;

  quadrant_autotile_selector_core u_top (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .kind               (kind),
    .col                (col),
    .row                (row),
    .cell_code          (cell_code),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_col            (out_col),
    .out_row            (out_row),
    .cell_class         (cell_class),
    .top_left_index     (top_left_index),
    .top_right_index    (top_right_index),
    .bottom_left_index  (bottom_left_index),
    .bottom_right_index (bottom_right_index),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // ---------------------------------------------------------------- predictor

  // Clamp a size register into 1..limit
  function automatic int fit_dim(input logic [qas_pkg::DIM_W-1:0] v, input int limit);
    if (v == 0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  function automatic int eff_cols();
    return fit_dim(width_reg, qas_pkg::MAX_COLS);
  endfunction

  function automatic int eff_rows();
    return fit_dim(height_reg, qas_pkg::MAX_ROWS);
  endfunction

  function automatic bit inside_map(input int r, input int c);
    return r >= 0 && c >= 0 && r < eff_rows() && c < eff_cols();
  endfunction

  // Off-map neighbors never match
  function automatic bit same_class(input int r, input int c, input bit cls);
    if (!inside_map(r, c)) return 1'b0;
    return class_map[r][c] == cls;
  endfunction

  function automatic logic [4:0] pick_subtile(input int quad, input bit d, input bit v,
                                              input bit h);
    subtile_col_e sel;
    if (v && h) sel = d ? SUB_SOLID : SUB_NOTCH;
    else if (v) sel = SUB_SIDE_V;
    else if (h) sel = SUB_SIDE_H;
    else sel = SUB_ISLAND;
    return subtile_lut[quad][sel];
  endfunction

  // Apply one accepted word: store a class, or queue the tile answer for a query
  function automatic void predict_word(input logic k, input logic [qas_pkg::COL_W-1:0] c,
                                       input logic [qas_pkg::ROW_W-1:0] r,
                                       input logic [7:0] code);
    tile_answer_t ans;
    int           ci;
    int           ri;
    bit           cls;
    bit           up;
    bit           dn;
    bit           lf;
    bit           rt;
    ci = int'(c);
    ri = int'(r);
    if (k == qas_pkg::KIND_WRITE) begin
      class_map[ri][ci] = (code == qas_pkg::WALL_CODE);
      cell_seen[ri][ci] = 1'b1;
      return;
    end
    if (!inside_map(ri, ci)) return;
    cls = class_map[ri][ci];
    up  = same_class(ri - 1, ci, cls);
    dn  = same_class(ri + 1, ci, cls);
    lf  = same_class(ri, ci - 1, cls);
    rt  = same_class(ri, ci + 1, cls);
    ans.col = c;
    ans.row = r;
    ans.cls = cls;
    ans.tl  = pick_subtile(int'(qas_pkg::QUAD_TL), same_class(ri - 1, ci - 1, cls), up, lf);
    ans.tr  = pick_subtile(int'(qas_pkg::QUAD_TR), same_class(ri - 1, ci + 1, cls), up, rt);
    ans.bl  = pick_subtile(int'(qas_pkg::QUAD_BL), same_class(ri + 1, ci - 1, cls), dn, lf);
    ans.br  = pick_subtile(int'(qas_pkg::QUAD_BR), same_class(ri + 1, ci + 1, cls), dn, rt);
    pending_tiles.push_back(ans);
  endfunction

  // ---------------------------------------------------------------- sender side

  function automatic logic [7:0] random_code();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return qas_pkg::WALL_CODE;
    if (roll < 6) return 8'h30;
    return 8'($urandom_range(0, 255));
  endfunction

  // Insert a gap at the end of a burst
  task automatic pace();
    int gap;
    if (!gaps_on) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 15);
    gap = $urandom_range(1, 6);
    in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  // Offer one word and hold it until the block takes it
  task automatic send_word(input logic k, input logic [qas_pkg::COL_W-1:0] c,
                           input logic [qas_pkg::ROW_W-1:0] r, input logic [7:0] code);
    in_valid  <= 1'b1;
    kind      <= k;
    col       <= c;
    row       <= r;
    cell_code <= code;
    do @(posedge clk); while (in_stall);
    words_sent++;
    predict_word(k, c, r, code);
    pace();
  endtask

  // Fill in any unwritten cell of the neighborhood, then query its center
  task automatic query_cell(input int c, input int r);
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (inside_map(r + dr, c + dc) && !cell_seen[r + dr][c + dc])
          send_word(qas_pkg::KIND_WRITE, qas_pkg::COL_W'(c + dc), qas_pkg::ROW_W'(r + dr),
                    random_code());
      end
    end
    send_word(qas_pkg::KIND_QUERY, qas_pkg::COL_W'(c), qas_pkg::ROW_W'(r),
              8'($urandom_range(0, 255)));
  endtask

  // Drop valid, wait for every expected result, then let the back end settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_tiles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_word(input logic [qas_pkg::CFG_IDX_W-1:0] idx,
                          input logic [qas_pkg::DIM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == qas_pkg::REG_MAP_WIDTH) width_reg = val;
    else if (idx == qas_pkg::REG_MAP_HEIGHT) height_reg = val;
  endtask

  task automatic set_dims(input logic [qas_pkg::DIM_W-1:0] w,
                          input logic [qas_pkg::DIM_W-1:0] h, input bit poke_spare);
    wait_idle();
    cfg_word(qas_pkg::REG_MAP_WIDTH, w);
    if (poke_spare) cfg_word(REG_SPARE_IDX, qas_pkg::DIM_W'($urandom_range(0, 127)));
    cfg_word(qas_pkg::REG_MAP_HEIGHT, h);
    cfg_valid <= 1'b0;
    shapes_tried++;
  endtask

  // ---------------------------------------------------------------- directed tests

  // 2x2 map; an unknown register index is written and must be ignored
  task automatic test_tiny_map();
    set_dims(7'd2, 7'd2, 1'b1);
    send_word(qas_pkg::KIND_WRITE, 6'd0, 6'd0, qas_pkg::WALL_CODE);
    send_word(qas_pkg::KIND_WRITE, 6'd1, 6'd0, qas_pkg::WALL_CODE);
    send_word(qas_pkg::KIND_WRITE, 6'd0, 6'd1, qas_pkg::WALL_CODE);
    send_word(qas_pkg::KIND_WRITE, 6'd1, 6'd1, 8'h30);
    send_word(qas_pkg::KIND_QUERY, 6'd0, 6'd0, 8'h00);
    send_word(qas_pkg::KIND_QUERY, 6'd1, 6'd1, 8'h00);
    // off the map: taken, no result
    send_word(qas_pkg::KIND_QUERY, 6'd2, 6'd0, 8'h00);
  endtask

  // Zero size acts as a single cell whose neighbors are all off the map
  task automatic test_one_cell();
    set_dims(7'd0, 7'd0, 1'b0);
    send_word(qas_pkg::KIND_QUERY, 6'd0, 6'd0, 8'hFF);
    send_word(qas_pkg::KIND_QUERY, 6'd0, 6'd1, 8'h00);
  endtask

  // Oversized width clamps to the store; work the far corner at field extremes
  task automatic test_far_corner();
    set_dims(7'd127, 7'd64, 1'b0);
    send_word(qas_pkg::KIND_WRITE, 6'd62, 6'd62, qas_pkg::WALL_CODE);
    send_word(qas_pkg::KIND_WRITE, 6'd63, 6'd62, qas_pkg::WALL_CODE);
    send_word(qas_pkg::KIND_WRITE, 6'd62, 6'd63, qas_pkg::WALL_CODE);
    send_word(qas_pkg::KIND_WRITE, 6'd63, 6'd63, qas_pkg::WALL_CODE);
    send_word(qas_pkg::KIND_QUERY, 6'd63, 6'd63, 8'hFF);
    send_word(qas_pkg::KIND_WRITE, 6'd63, 6'd63, 8'hFF);
    send_word(qas_pkg::KIND_WRITE, 6'd62, 6'd62, 8'h00);
    send_word(qas_pkg::KIND_QUERY, 6'd63, 6'd63, 8'h00);
  endtask

  // 3x3 map with a floor center and a wall corner that sees a notch
  task automatic test_three_by_three();
    set_dims(7'd3, 7'd3, 1'b0);
    send_word(qas_pkg::KIND_WRITE, 6'd2, 6'd0, qas_pkg::WALL_CODE);
    send_word(qas_pkg::KIND_WRITE, 6'd2, 6'd1, 8'h00);
    send_word(qas_pkg::KIND_WRITE, 6'd2, 6'd2, 8'h30);
    send_word(qas_pkg::KIND_WRITE, 6'd0, 6'd2, 8'h30);
    send_word(qas_pkg::KIND_WRITE, 6'd1, 6'd2, qas_pkg::WALL_CODE);
    send_word(qas_pkg::KIND_QUERY, 6'd1, 6'd1, 8'h00);
    send_word(qas_pkg::KIND_QUERY, 6'd0, 6'd0, 8'h00);
  endtask

  // Hold the output off for a long stretch while queries keep coming
  task automatic test_output_hold_off();
    set_dims(7'd8, 7'd8, 1'b0);
    gaps_on = 1'b0;
    hold_off_req = 200;
    repeat (30) query_cell($urandom_range(0, 7), $urandom_range(0, 7));
    gaps_on = 1'b1;
    // pause until every answer is back
    wait_idle();
  endtask

  // ---------------------------------------------------------------- random traffic

  function automatic logic [qas_pkg::DIM_W-1:0] random_dim();
    case ($urandom_range(0, 9))
      0: return 7'd0;
      1: return 7'd64;
      2: return qas_pkg::DIM_W'($urandom_range(65, 127));
      3: return qas_pkg::DIM_W'($urandom_range(9, 63));
      default: return qas_pkg::DIM_W'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic random_word();
    int roll;
    int c;
    int r;
    roll = $urandom_range(0, 99);
    if (roll < 65) begin
      // well-formed query near the phase's working region
      c = region_c + $urandom_range(0, 5);
      r = region_r + $urandom_range(0, 5);
      if (c >= eff_cols()) c = eff_cols() - 1;
      if (r >= eff_rows()) r = eff_rows() - 1;
      query_cell(c, r);
    end else if (roll < 80) begin
      send_word(qas_pkg::KIND_WRITE, qas_pkg::COL_W'($urandom_range(0, 63)),
                qas_pkg::ROW_W'($urandom_range(0, 63)), random_code());
    end else if (roll < 90) begin
      c = $urandom_range(0, 63);
      r = $urandom_range(0, 63);
      if (inside_map(r, c)) query_cell(c, r);
      else send_word(qas_pkg::KIND_QUERY, qas_pkg::COL_W'(c), qas_pkg::ROW_W'(r),
                     8'($urandom_range(0, 255)));
    end else begin
      query_cell($urandom_range(0, eff_cols() - 1), $urandom_range(0, eff_rows() - 1));
    end
  endtask

  task automatic test_random_traffic();
    int start;
    int n;
    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) begin
      set_dims(random_dim(), random_dim(), $urandom_range(0, 3) == 0);
      gaps_on  = $urandom_range(0, 3) != 0;
      region_c = $urandom_range(0, eff_cols() - 1);
      region_r = $urandom_range(0, eff_rows() - 1);
      n = $urandom_range(40, 120);
      repeat (n) begin
        if (words_sent - start < RANDOM_WORDS) random_word();
      end
    end
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------- result side

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_tile();
    tile_answer_t want;
    if (pending_tiles.size() == 0) begin
      $error("unexpected result word: col %0d row %0d", out_col, out_row);
      mismatch_count++;
      return;
    end
    want = pending_tiles.pop_front();
    tiles_checked++;
    check_field("out_col", int'(want.col), int'(out_col));
    check_field("out_row", int'(want.row), int'(out_row));
    check_field("cell_class", int'(want.cls), int'(cell_class));
    check_field("top_left_index", int'(want.tl), int'(top_left_index));
    check_field("top_right_index", int'(want.tr), int'(top_right_index));
    check_field("bottom_left_index", int'(want.bl), int'(bottom_left_index));
    check_field("bottom_right_index", int'(want.br), int'(bottom_right_index));
  endtask

  // Check taken results, then choose the next stall value
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) check_tile();
      if (hold_off_req > 0) begin
        hold_left = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        if (stretch_left == 0) begin
          stall_mode   = stall_mode_e'($urandom_range(0, 3));
          stretch_left = $urandom_range(10, 60);
        end
        stretch_left--;
        stall_phase++;
        case (stall_mode)
          STALL_NONE:        stall_next = 1'b0;
          STALL_LIGHT:       stall_next = $urandom_range(0, 99) < 40;
          STALL_EVERY_THIRD: stall_next = (stall_phase % 3) == 0;
          default:           stall_next = $urandom_range(0, 99) < 80;
        endcase
      end
      out_stall <= stall_next;
    end
  end

  // Hard stop if the run hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_tiles.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_tiny_map();
    test_one_cell();
    test_far_corner();
    test_three_by_three();
    test_output_hold_off();
    test_random_traffic();
    wait_idle();
    $display("covered %0d words over %0d map shapes; %0d tile answers checked",
             words_sent, shapes_tried, tiles_checked);
    if (mismatch_count == 0 && pending_tiles.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== quadrant_autotile_selector_core.f =====
hw/rtl/qas_pkg.sv
hw/rtl/qas_front.sv
hw/rtl/qas_queue.sv
hw/rtl/qas_back.sv
hw/rtl/quadrant_autotile_selector_core.sv
tb/quadrant_autotile_selector_core_tb.sv
